>>> design/timed_event_queue_assert.svh
// assertion macros shared by the checker
`ifndef TIMED_EVENT_QUEUE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TEVQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tevq check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define TEVQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tevq check failed");

`endif

>>> design/tevq_pkg.sv
package tevq_pkg;

  typedef enum logic [1:0] {
    OP_SCHEDULE   = 2'd0,
    OP_UNSCHEDULE = 2'd1,
    OP_QUERY      = 2'd2,
    OP_PROGRESS   = 2'd3
  } tevq_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } tevq_status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  event_type;
    logic [63:0] start_clock;
    logic [63:0] target_clock;
    logic        is_periodic;
    logic [31:0] period_clocks;
  } tevq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  out_type;
    logic [63:0] out_start;
    logic [63:0] out_target;
    logic        out_periodic;
    logic [31:0] out_period;
    logic [63:0] now_clock;
    logic [4:0]  queued;
  } tevq_out_t;

  // one stored event
  typedef struct packed {
    logic [3:0]  etype;
    logic [63:0] start;
    logic [63:0] target;
    logic        periodic;
    logic [31:0] period;
  } tevq_entry_t;

  // decoded command passed from front to back
  typedef struct packed {
    tevq_op_e    op;
    tevq_entry_t ev;
  } tevq_cmd_t;

endpackage

>>> design/tevq_front.sv
module tevq_front
  import tevq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tevq_in_t  in_data_i,
  output logic      cmd_valid_o,
  output tevq_cmd_t cmd_o,
  input  logic      cmd_pop_i
);

  tevq_cmd_t  buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  tevq_cmd_t  dec;

  // decode the transaction into a command
  always_comb begin
    dec.op          = tevq_op_e'(in_data_i.op);
    dec.ev.etype    = in_data_i.event_type;
    dec.ev.start    = in_data_i.start_clock;
    dec.ev.target   = in_data_i.target_clock;
    dec.ev.periodic = in_data_i.is_periodic;
    dec.ev.period   = in_data_i.period_clocks;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= dec;
    end
  end

endmodule

>>> design/tevq_back.sv
module tevq_back
  import tevq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  tevq_cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tevq_out_t out_data_o
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_EV,
    S_UNS_CHK,
    S_UNS_EV,
    S_QRY_CHK,
    S_QRY_EV,
    S_POP_EV,
    S_SHF_CHK,
    S_SHF_EV
  } state_e;

  state_e      state_q, state_d;
  tevq_cmd_t   cmd_q, cmd_d;
  tevq_entry_t ev_q, ev_d;
  tevq_entry_t popped_q, popped_d;
  logic [CW-1:0] k_q, k_d, i_q, i_d, j_q, j_d, fill_q, fill_d;
  logic [CW-1:0] k_m1, i_m1;
  logic [63:0] now_q, now_d;
  tevq_out_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  tevq_entry_t mem [QUEUE_DEPTH];
  tevq_entry_t rdata_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  tevq_entry_t   mem_wdata;

  logic         fin, fin_has_ev;
  tevq_status_e fin_status;
  tevq_entry_t  fin_ev;
  logic [CW+4:0] fill_ext;

  assign k_m1 = k_q - CW'(1);
  assign i_m1 = i_q - CW'(1);
  assign fill_ext = {5'd0, fill_d};

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    ev_d        = ev_q;
    popped_d    = popped_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    fill_d      = fill_q;
    now_d       = now_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = ev_q;
    mem_raddr   = '0;
    fin         = 1'b0;
    fin_has_ev  = 1'b0;
    fin_status  = ST_OK;
    fin_ev      = popped_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && (!out_valid_q || !out_stall_i)) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.op)
            OP_SCHEDULE: begin
              if (fill_q == CW'(QUEUE_DEPTH)) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                ev_d    = cmd_i.ev;
                k_d     = fill_q;
                state_d = S_INS_CHK;
              end
            end
            OP_UNSCHEDULE: begin
              i_d     = '0;
              j_d     = '0;
              state_d = S_UNS_CHK;
            end
            OP_QUERY: begin
              i_d     = '0;
              state_d = S_QRY_CHK;
            end
            OP_PROGRESS: begin
              if (fill_q == '0) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                mem_raddr = '0;
                state_d   = S_POP_EV;
              end
            end
            default: ;
          endcase
        end
      end
      // insertion walks from the tail toward the head
      S_INS_CHK: begin
        if (k_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = ev_q;
          fill_d    = fill_q + CW'(1);
          fin       = 1'b1;
          fin_has_ev = (cmd_q.op == OP_PROGRESS);
        end else begin
          mem_raddr = k_m1[IW-1:0];
          state_d   = S_INS_EV;
        end
      end
      S_INS_EV: begin
        mem_we    = 1'b1;
        mem_waddr = k_q[IW-1:0];
        if (rdata_q.target > ev_q.target) begin
          mem_wdata = rdata_q;
          k_d       = k_m1;
          state_d   = S_INS_CHK;
        end else begin
          mem_wdata  = ev_q;
          fill_d     = fill_q + CW'(1);
          fin        = 1'b1;
          fin_has_ev = (cmd_q.op == OP_PROGRESS);
        end
      end
      S_UNS_CHK: begin
        if (i_q == fill_q) begin
          fill_d = j_q;
          fin    = 1'b1;
        end else begin
          mem_raddr = i_q[IW-1:0];
          state_d   = S_UNS_EV;
        end
      end
      S_UNS_EV: begin
        if (rdata_q.etype != cmd_q.ev.etype) begin
          mem_we    = 1'b1;
          mem_waddr = j_q[IW-1:0];
          mem_wdata = rdata_q;
          j_d       = j_q + CW'(1);
        end
        i_d     = i_q + CW'(1);
        state_d = S_UNS_CHK;
      end
      S_QRY_CHK: begin
        if (i_q == fill_q) begin
          fin        = 1'b1;
          fin_status = ST_NOT_FOUND;
        end else begin
          mem_raddr = i_q[IW-1:0];
          state_d   = S_QRY_EV;
        end
      end
      S_QRY_EV: begin
        if (rdata_q.etype == cmd_q.ev.etype) begin
          fin        = 1'b1;
          fin_has_ev = 1'b1;
          fin_ev     = rdata_q;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_QRY_CHK;
        end
      end
      S_POP_EV: begin
        popped_d = rdata_q;
        now_d    = rdata_q.target;
        i_d      = CW'(1);
        state_d  = S_SHF_CHK;
      end
      S_SHF_CHK: begin
        if (i_q == fill_q) begin
          fill_d = fill_q - CW'(1);
          if (popped_q.periodic) begin
            ev_d        = popped_q;
            ev_d.start  = popped_q.target;
            ev_d.target = popped_q.target + {32'd0, popped_q.period};
            k_d         = fill_q - CW'(1);
            state_d     = S_INS_CHK;
          end else begin
            fin        = 1'b1;
            fin_has_ev = 1'b1;
          end
        end else begin
          mem_raddr = i_q[IW-1:0];
          state_d   = S_SHF_EV;
        end
      end
      S_SHF_EV: begin
        mem_we    = 1'b1;
        mem_waddr = i_m1[IW-1:0];
        mem_wdata = rdata_q;
        i_d       = i_q + CW'(1);
        state_d   = S_SHF_CHK;
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      state_d            = S_IDLE;
      out_valid_d        = 1'b1;
      out_d.status       = fin_status;
      out_d.out_type     = fin_has_ev ? fin_ev.etype : 4'd0;
      out_d.out_start    = fin_has_ev ? fin_ev.start : 64'd0;
      out_d.out_target   = fin_has_ev ? fin_ev.target : 64'd0;
      out_d.out_periodic = fin_has_ev && fin_ev.periodic;
      out_d.out_period   = fin_has_ev ? fin_ev.period : 32'd0;
      out_d.now_clock    = now_d;
      out_d.queued       = fill_ext[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      now_q       <= 64'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    ev_q     <= ev_d;
    popped_q <= popped_d;
    k_q      <= k_d;
    i_q      <= i_d;
    j_q      <= j_d;
    out_q    <= out_d;
  end

  // event store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/timed_event_queue.sv
// channel | direction | handshake              | payload
// input   | in        | in_valid_i / in_stall_o  | in_data_i  (tevq_in_t)
// result  | out       | out_valid_o / out_stall_i | out_data_o (tevq_out_t)
//
// the back end takes one transaction at a time and walks the store for it entry by entry;
// a full schedule or an empty progress answers without a walk, and a periodic progress
// shifts the store down and then re-inserts the popped event at its next target
// one result per transaction, in order
// reset (rst_ni low, async) empties the queue and zeroes the progress clock
// a stalled result holds; the front keeps taking up to two transactions meanwhile
module timed_event_queue
  import tevq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tevq_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tevq_out_t out_data_o
);

  // decoded commands waiting for the back end
  logic      cmd_valid;
  logic      cmd_pop;
  tevq_cmd_t cmd;

  // front: accepts transactions and queues decoded commands
  tevq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: walks the sorted event store and registers the result
  tevq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/timed_event_queue_chk.sv
`include "timed_event_queue_assert.svh"

module timed_event_queue_chk
  import tevq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input tevq_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input tevq_out_t out_data_o
);

  localparam logic [4:0] FullQueued = 5'(QUEUE_DEPTH);

  `TEVQ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `TEVQ_ASSERT_NOW(a_empty_report, out_valid_o && out_data_o.status == ST_EMPTY, out_data_o.queued == 5'd0 && out_data_o.out_target == 64'd0)
  `TEVQ_ASSERT_NOW(a_full_report, out_valid_o && out_data_o.status == ST_FULL, out_data_o.queued == FullQueued && !out_data_o.out_periodic)
  `TEVQ_ASSERT_NOW(a_miss_report, out_valid_o && out_data_o.status == ST_NOT_FOUND, out_data_o.out_target == 64'd0 && out_data_o.out_period == 32'd0)

endmodule

bind timed_event_queue timed_event_queue_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (.*);
